### src/qpx_pkg.sv
// ----------------------------------------------------------------------------
// qpx_pkg: shared types and helpers for the query parameter extractor
// holds parse state, result record, character codes and small decoders
// ----------------------------------------------------------------------------
package qpx_pkg;

  localparam int unsigned MaxKeyBytes = 8;
  localparam int unsigned KeyIdxW     = $clog2(MaxKeyBytes);
  localparam int unsigned KeyLenW     = 4;
  localparam int unsigned KeyW        = 8 * MaxKeyBytes;

  // configuration register indexes
  localparam logic CfgWantedKey    = 1'b0;
  localparam logic CfgWantedKeyLen = 1'b1;

  // character codes
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef enum logic [2:0] {
    PhStart,
    PhKey,
    PhValue,
    PhSkip,
    PhIdle
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [KeyLenW-1:0] key_pos;
    logic               key_mismatch;
    logic [1:0]         esc_cnt;
    logic [3:0]         high_nib;
    logic               match_done;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       key_found;
  } result_t;

  localparam parse_state_t StateReset = '{
    phase:        PhStart,
    key_pos:      '0,
    key_mismatch: 1'b0,
    esc_cnt:      2'd0,
    high_nib:     4'd0,
    match_done:   1'b0
  };

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    lower_ascii = (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'h20) : c;
  endfunction

  // non-hex digits count as zero
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = 8'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = 8'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = 8'(c - 8'h57);
    end
    hex_val = t[3:0];
  endfunction

endpackage

### src/query_param_extract_url_decode.sv
// ----------------------------------------------------------------------------
// query_param_extract_url_decode: query string parameter extractor
// finds the first part whose key matches and emits its value url-decoded
// ----------------------------------------------------------------------------
// The block takes one character of a query or form string per transfer and
// keeps up with one transfer every clock cycle while out_stall_i is low. Each
// character goes through an input register, the parse logic and a result
// register, in that order. Parts are split on '&', leading '=' are skipped,
// and the key is compared without regard to case against wanted_key
// (wanted_key_length bytes, capped at eight). Value bytes of the first
// matching part come out one per transfer with byte_valid set; '+' becomes
// a space and '%HH' one byte. The character marked by in_last always gives
// a result with done_res set and key_found telling whether the key was seen;
// the parse then starts afresh. The user must write the configuration
// registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module query_param_extract_url_decode import qpx_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration writes
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [KeyW-1:0] cfg_data_i,
  // character input
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  // result output
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      value_byte_o,
  output logic            byte_valid_o,
  output logic            done_res_o,
  output logic            key_found_o
);

  // configuration registers
  logic [KeyW-1:0]    key_q;
  logic [KeyLenW-1:0] key_len_q;
  logic [KeyLenW-1:0] key_len_eff;

  // input register
  logic               in_vld_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;

  // parse state and result register
  parse_state_t       state_q;
  parse_state_t       state_d;
  result_t            res_d;
  result_t            res_q;

  logic               out_free;
  logic               step_fire;
  logic               in_accept;

  // lengths above the key store are treated as full length
  assign key_len_eff = (key_len_q > KeyLenW'(MaxKeyBytes)) ? KeyLenW'(MaxKeyBytes)
                                                          : key_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= KeyLenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWantedKey:    key_q     <= cfg_data_i;
        CfgWantedKeyLen: key_len_q <= cfg_data_i[KeyLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  // the result slot is free when empty or being taken this cycle
  assign out_free   = !res_q.valid || !out_stall_i;
  // the held character is parsed only once its result has somewhere to go
  assign step_fire  = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  qpx_step u_step (
    .state_i   (state_q),
    .char_i    (in_byte_q),
    .last_i    (in_last_q),
    .key_i     (key_q),
    .key_len_i (key_len_eff),
    .state_o   (state_d),
    .res_o     (res_d)
  );

  // parse state moves on once per parsed character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // result register: only characters that give a result fill it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (out_free) begin
      res_q.valid <= step_fire && res_d.valid;
      if (step_fire && res_d.valid) begin
        res_q.value_byte <= res_d.value_byte;
        res_q.byte_valid <= res_d.byte_valid;
        res_q.done_res   <= res_d.done_res;
        res_q.key_found  <= res_d.key_found;
      end
    end
  end

  assign out_valid_o  = res_q.valid;
  assign value_byte_o = res_q.value_byte;
  assign byte_valid_o = res_q.byte_valid;
  assign done_res_o   = res_q.done_res;
  assign key_found_o  = res_q.key_found;

endmodule

### src/qpx_key_cmp.sv
// ----------------------------------------------------------------------------
// qpx_key_cmp: one key character against the wanted name
// case-insensitive compare at the running key position
// ----------------------------------------------------------------------------
module qpx_key_cmp import qpx_pkg::*; (
  input  logic [KeyW-1:0]    key_i,
  input  logic [KeyLenW-1:0] key_len_i,
  input  logic [KeyLenW-1:0] pos_i,
  input  logic               mismatch_i,
  input  logic [7:0]         char_i,
  output logic [KeyLenW-1:0] pos_o,
  output logic               mismatch_o
);

  logic [MaxKeyBytes-1:0][7:0] key_bytes;
  logic [7:0]                  want;

  assign key_bytes = key_i;
  assign want      = key_bytes[pos_i[KeyIdxW-1:0]];

  always_comb begin
    pos_o      = pos_i;
    mismatch_o = 1'b1;
    if (pos_i < key_len_i) begin
      pos_o      = KeyLenW'(pos_i + 1'b1);
      mismatch_o = mismatch_i | (lower_ascii(char_i) != lower_ascii(want));
    end
  end

endmodule

### src/qpx_step.sv
// ----------------------------------------------------------------------------
// qpx_step: parser step for one character
// next parse state and the result record for one transfer
// ----------------------------------------------------------------------------
module qpx_step import qpx_pkg::*; (
  input  parse_state_t       state_i,
  input  logic [7:0]         char_i,
  input  logic               last_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [KeyLenW-1:0] key_len_i,
  output parse_state_t       state_o,
  output result_t            res_o
);

  logic               at_start;
  logic [KeyLenW-1:0] cmp_pos_in;
  logic               cmp_mis_in;
  logic [KeyLenW-1:0] cmp_pos;
  logic               cmp_mis;
  logic               cur_match;
  logic               nxt_match;
  logic               have;
  logic [7:0]         ob;
  parse_state_t       nxt;

  // a new part restarts the compare at the first key byte
  assign at_start   = (state_i.phase == PhStart);
  assign cmp_pos_in = at_start ? '0 : state_i.key_pos;
  assign cmp_mis_in = at_start ? 1'b0 : state_i.key_mismatch;

  qpx_key_cmp u_key_cmp (
    .key_i      (key_i),
    .key_len_i  (key_len_i),
    .pos_i      (cmp_pos_in),
    .mismatch_i (cmp_mis_in),
    .char_i     (char_i),
    .pos_o      (cmp_pos),
    .mismatch_o (cmp_mis)
  );

  assign cur_match = !state_i.key_mismatch && (state_i.key_pos == key_len_i);

  always_comb begin
    nxt  = state_i;
    have = 1'b0;
    ob   = 8'h00;
    unique case (state_i.phase)
      PhStart: begin
        if (char_i != ChEq && char_i != ChAmp) begin
          nxt.key_pos      = cmp_pos;
          nxt.key_mismatch = cmp_mis;
          nxt.phase        = PhKey;
        end
      end
      PhKey: begin
        if (char_i == ChEq) begin
          if (cur_match) begin
            nxt.match_done = 1'b1;
            nxt.esc_cnt    = 2'd0;
            nxt.phase      = PhValue;
          end else begin
            nxt.phase = PhSkip;
          end
        end else if (char_i == ChAmp) begin
          if (cur_match) begin
            nxt.match_done = 1'b1;
            nxt.phase      = PhIdle;
          end else begin
            nxt.phase = PhStart;
          end
        end else begin
          nxt.key_pos      = cmp_pos;
          nxt.key_mismatch = cmp_mis;
        end
      end
      PhValue: begin
        if (char_i == ChAmp) begin
          // an escape cut short here yields nothing
          nxt.esc_cnt = 2'd0;
          nxt.phase   = PhIdle;
        end else if (state_i.esc_cnt == 2'd1) begin
          nxt.high_nib = hex_val(char_i);
          nxt.esc_cnt  = 2'd2;
        end else if (state_i.esc_cnt == 2'd2) begin
          ob          = {state_i.high_nib, hex_val(char_i)};
          nxt.esc_cnt = 2'd0;
          have        = 1'b1;
        end else if (char_i == ChPercent) begin
          nxt.esc_cnt = 2'd1;
        end else if (char_i == ChPlus) begin
          ob   = ChSpace;
          have = 1'b1;
        end else begin
          ob   = char_i;
          have = 1'b1;
        end
        // a zero byte ends the value
        if (have && ob == 8'h00) begin
          have      = 1'b0;
          nxt.phase = PhIdle;
        end
      end
      PhSkip: begin
        if (char_i == ChAmp) begin
          nxt.phase = PhStart;
        end
      end
      default: begin
      end
    endcase
  end

  assign nxt_match = !nxt.key_mismatch && (nxt.key_pos == key_len_i);

  always_comb begin
    res_o.valid      = have || last_i;
    res_o.value_byte = have ? ob : 8'h00;
    res_o.byte_valid = have;
    res_o.done_res   = last_i;
    res_o.key_found  = last_i && (nxt.match_done || (nxt.phase == PhKey && nxt_match));
    state_o          = last_i ? StateReset : nxt;
  end

endmodule

### src/qpx_checker.sv
// ----------------------------------------------------------------------------
// qpx_checker: port-level checks for the query parameter extractor
// watches the result channel and is bound to the top level
// ----------------------------------------------------------------------------
module qpx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] value_byte_o,
  input logic       byte_valid_o,
  input logic       done_res_o,
  input logic       key_found_o
);

  // every result carries a byte or ends the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o || done_res_o))
    else $error("result with neither byte nor done");

  // key found is only reported with done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_found_o) |-> done_res_o)
    else $error("key_found without done_res");

  // a zero byte ends the value, so is never emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |-> (value_byte_o != 8'h00))
    else $error("zero value byte emitted");

  // no byte means a zero byte field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (value_byte_o == 8'h00))
    else $error("value_byte set without byte_valid");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_byte_o)
                                      && $stable(done_res_o)))
    else $error("stalled result changed");

endmodule

bind query_param_extract_url_decode qpx_checker u_qpx_checker (.*);

### dv/query_param_extract_url_decode_tb.sv
// ----------------------------------------------------------------------------
// query_param_extract_url_decode_tb: self-checking bench for the extractor
// streams query strings through the block, decodes them alongside in a
// behavioural model of the parser and compares every result transfer
// ----------------------------------------------------------------------------
module query_param_extract_url_decode_tb;
  import qpx_pkg::*;

  // one raw character on its way into the block
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // one result transfer as the block should present it
  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       key_found;
  } decoded_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            cfg_we_i     = 1'b0;
  logic            cfg_index_i  = CfgWantedKey;
  logic [KeyW-1:0] cfg_data_i   = '0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  logic [7:0]      in_byte_i    = 8'h00;
  logic            in_last_i    = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  logic [7:0]      value_byte_o;
  logic            byte_valid_o;
  logic            done_res_o;
  logic            key_found_o;

  // characters still to be offered, and decoded results still owed
  char_item_t      chars_waiting[$];
  decoded_t        decoded_due[$];
  logic [7:0]      text[$];

  // bench view of the configuration registers
  logic [KeyW-1:0] want_key = '0;
  logic [3:0]      want_len = 4'd1;

  // parser state mirrored by the bench
  phase_e          scan_phase  = PhStart;
  logic [3:0]      key_idx     = 4'd0;
  logic            key_bad     = 1'b0;
  logic [1:0]      esc_left    = 2'd0;
  logic [3:0]      esc_high    = 4'd0;
  logic            value_taken = 1'b0;

  int unsigned     idle_pct    = 0;
  int unsigned     stall_pct   = 0;
  int unsigned     hold_cycles = 0;
  int unsigned     mismatches  = 0;
  logic            took        = 1'b0;

  query_param_extract_url_decode uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_byte_o (value_byte_o),
    .byte_valid_o (byte_valid_o),
    .done_res_o   (done_res_o),
    .key_found_o  (key_found_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // generous ceiling, far beyond the slowest legal run
  initial begin
    #3600000;
    $display("** query_param_extract_url_decode: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // behavioural model of the parser
  // ---------------------------------------------------------------------------

  // ascii upper case folds onto lower case, everything else is left alone
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c | 8'h20;
    end
    return c;
  endfunction

  // a digit that is not hex is worth nothing
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return 4'(c - "0");
    end
    if (fold_case(c) >= "a" && fold_case(c) <= "f") begin
      return 4'(fold_case(c) - "a" + 10);
    end
    return 4'd0;
  endfunction

  // lengths above the key store are capped, zero means nothing can match
  function automatic int unsigned key_span();
    return (want_len > MaxKeyBytes) ? MaxKeyBytes : int'(want_len);
  endfunction

  function automatic void take_key_char(input logic [7:0] c);
    if (key_idx < key_span()) begin
      if (fold_case(c) != fold_case(want_key[8*key_idx +: 8])) begin
        key_bad = 1'b1;
      end
      key_idx = key_idx + 4'd1;
    end else begin
      key_bad = 1'b1;
    end
  endfunction

  function automatic logic key_hit();
    return !key_bad && (key_idx == key_span());
  endfunction

  // advance the parse by one character and queue whatever it should emit
  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic       have;
    logic [7:0] ob;
    logic       found;
    have = 1'b0;
    ob   = 8'h00;
    case (scan_phase)
      PhStart: begin
        if (c != ChEq && c != ChAmp) begin
          key_idx = 4'd0;
          key_bad = 1'b0;
          take_key_char(c);
          scan_phase = PhKey;
        end
      end
      PhKey: begin
        if (c == ChEq) begin
          if (key_hit()) begin
            value_taken = 1'b1;
            esc_left    = 2'd0;
            scan_phase  = PhValue;
          end else begin
            scan_phase = PhSkip;
          end
        end else if (c == ChAmp) begin
          // a bare key with no '=' still counts as found
          if (key_hit()) begin
            value_taken = 1'b1;
            scan_phase  = PhIdle;
          end else begin
            scan_phase = PhStart;
          end
        end else begin
          take_key_char(c);
        end
      end
      PhValue: begin
        if (c == ChAmp) begin
          // a half-finished escape is simply dropped
          esc_left   = 2'd0;
          scan_phase = PhIdle;
        end else if (esc_left == 2'd1) begin
          esc_high = nibble_of(c);
          esc_left = 2'd2;
        end else if (esc_left == 2'd2) begin
          ob       = {esc_high, nibble_of(c)};
          esc_left = 2'd0;
          have     = 1'b1;
        end else if (c == ChPercent) begin
          esc_left = 2'd1;
        end else if (c == ChPlus) begin
          ob   = ChSpace;
          have = 1'b1;
        end else begin
          ob   = c;
          have = 1'b1;
        end
        // a zero byte, raw or decoded, closes the value silently
        if (have && ob == 8'h00) begin
          have       = 1'b0;
          scan_phase = PhIdle;
        end
      end
      PhSkip: begin
        if (c == ChAmp) begin
          scan_phase = PhStart;
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      found = value_taken | (scan_phase == PhKey && key_hit());
      decoded_due.push_back('{have ? ob : 8'h00, have, 1'b1, found});
      scan_phase  = PhStart;
      key_idx     = 4'd0;
      key_bad     = 1'b0;
      esc_left    = 2'd0;
      esc_high    = 4'd0;
      value_taken = 1'b0;
    end else if (have) begin
      decoded_due.push_back('{ob, 1'b1, 1'b0, 1'b0});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch, got %02h, expected %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    decoded_t want;
    if (decoded_due.size() == 0) begin
      report_mismatch("unexpected transfer", value_byte_o, 8'h00);
    end else begin
      want = decoded_due.pop_front();
      if (value_byte_o !== want.value_byte) begin
        report_mismatch("value_byte", value_byte_o, want.value_byte);
      end
      if (byte_valid_o !== want.byte_valid) begin
        report_mismatch("byte_valid", 8'(byte_valid_o), 8'(want.byte_valid));
      end
      if (done_res_o !== want.done_res) begin
        report_mismatch("done_res", 8'(done_res_o), 8'(want.done_res));
      end
      if (key_found_o !== want.key_found) begin
        report_mismatch("key_found", 8'(key_found_o), 8'(want.key_found));
      end
    end
  endtask

  // everything is sampled on the rising edge; results are checked before the
  // character taken on the same edge is decoded, as no result can overtake it
  always @(posedge clk_i) begin
    took = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result();
      end
      if (in_valid_i && !in_stall_o) begin
        took = 1'b1;
        decode_char(in_byte_i, in_last_i);
        void'(chars_waiting.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver and receiver, both acting on the falling edge
  // ---------------------------------------------------------------------------

  // an offered character is held until its transfer; otherwise the next one
  // is offered or the sender idles, never looking at the stall
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !took)) begin
      if (chars_waiting.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_byte_i  <= chars_waiting[0].ch;
        in_last_i  <= chars_waiting[0].last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // random stalls, or a long hold-off counted down here
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // sender stops until every owed result has left
  task automatic wait_drained();
    while (chars_waiting.size() != 0 || in_valid_i || decoded_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [KeyW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CfgWantedKey) begin
      want_key = data;
    end else begin
      want_len = data[3:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_key(input logic [KeyW-1:0] key, input logic [3:0] len);
    write_reg(CfgWantedKey, key);
    write_reg(CfgWantedKeyLen, KeyW'(len));
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return flip_case(8'($urandom_range(97, 122)));
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return 8'(48 + v);
    end
    return 8'(($urandom_range(0, 1) ? 65 : 97) + v - 10);
  endfunction

  // 'g' to 'z' in either case: never a hex digit, never a separator
  function automatic logic [7:0] non_hex_char();
    return flip_case(8'($urandom_range(103, 122)));
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    logic [KeyW-1:0] k;
    for (int i = 0; i < MaxKeyBytes; i++) begin
      k[8*i +: 8] = rand_letter();
    end
    return k;
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text.push_back(s[i]);
    end
  endtask

  // hand the built string to the driver, last flag on its final character
  task automatic send_text(output int unsigned n);
    if (text.size() == 0) begin
      text.push_back("a");
    end
    n = text.size();
    foreach (text[i]) begin
      chars_waiting.push_back('{text[i], i == text.size() - 1});
    end
    text.delete();
  endtask

  // half the time the wanted key in mixed case, otherwise near misses and strangers
  task automatic add_key();
    int unsigned n;
    int unsigned j;
    n = key_span();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        for (int i = 0; i < n; i++) text.push_back(flip_case(want_key[8*i +: 8]));
      end
      5: begin
        for (int i = 0; i + 1 < n; i++) text.push_back(flip_case(want_key[8*i +: 8]));
        if (n <= 1) text.push_back(rand_letter());
      end
      6: begin
        for (int i = 0; i < n; i++) text.push_back(flip_case(want_key[8*i +: 8]));
        text.push_back(rand_letter());
      end
      7: begin
        j = $urandom_range(0, (n == 0) ? 0 : n - 1);
        for (int i = 0; i < n; i++) begin
          text.push_back((i == j) ? rand_letter() : want_key[8*i +: 8]);
        end
      end
      default: begin
        repeat ($urandom_range(1, 5)) text.push_back(rand_letter());
      end
    endcase
  endtask

  task automatic add_value();
    logic [7:0] c;
    repeat ($urandom_range(0, 7)) begin
      case ($urandom_range(0, 19))
        0, 1: text.push_back(ChPlus);
        2, 3, 4: begin
          text.push_back(ChPercent);
          text.push_back(hex_char());
          text.push_back(hex_char());
        end
        5: begin
          text.push_back(ChPercent);
          text.push_back(non_hex_char());
          text.push_back(hex_char());
        end
        6: begin
          text.push_back(ChPercent);
          text.push_back(hex_char());
          text.push_back(non_hex_char());
        end
        7: text.push_back(8'($urandom_range(128, 255)));
        8: text.push_back(ChEq);
        9: begin
          // now and then an escaped zero that ends the value
          if ($urandom_range(0, 7) == 0) begin
            push_str("%00");
          end else begin
            text.push_back(ChSpace);
          end
        end
        10: text.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : rand_letter());
        default: begin
          c = 8'($urandom_range(33, 126));
          text.push_back((c == ChAmp) ? 8'h5F : c);
        end
      endcase
    end
  endtask

  task automatic add_part();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) text.push_back(ChEq);
    end
    add_key();
    if ($urandom_range(0, 6) != 0) begin
      text.push_back(ChEq);
      add_value();
    end
  endtask

  // a well-formed query string with random content and the odd flaw
  task automatic add_query();
    int unsigned parts;
    parts = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) text.push_back(ChAmp);
    for (int p = 0; p < parts; p++) begin
      if (p != 0) begin
        text.push_back(ChAmp);
        if ($urandom_range(0, 7) == 0) text.push_back(ChAmp);
      end
      add_part();
    end
    case ($urandom_range(0, 11))
      0: text.push_back(ChPercent);
      1: begin
        text.push_back(ChPercent);
        text.push_back(hex_char());
      end
      2: text.push_back(ChAmp);
      default: begin
      end
    endcase
  endtask

  task automatic run_strings(input int unsigned count);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        // plain noise, every byte value possible
        repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_query();
      end
      send_text(n);
      sent += n;
    end
  endtask

  initial begin
    int unsigned n;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings, single character key 'k', no idling
    set_key(KeyW'("k"), 4'd1);
    // skipped '=', empty part, key in upper case, escape, plus, cut escape at end
    push_str("=&=K=%4g+%z");
    send_text(n);
    // extreme byte as a stray key, then a bare key closing the string
    text.push_back(8'hFF);
    push_str("x&k");
    send_text(n);
    // escape cut short by '&'
    push_str("k=a%1&");
    send_text(n);
    // raw zero byte ends the value
    push_str("k=");
    text.push_back(8'h00);
    push_str("z");
    send_text(n);
    wait_drained();

    // four-letter key, full throughput both ways
    set_key(KeyW'("egap"), 4'd4);
    run_strings(290);
    wait_drained();

    // longest key, sender idle most of the time
    set_key(rand_key(), 4'd8);
    idle_pct = 64;
    run_strings(290);
    wait_drained();

    // length field above the key store, receiver stalling heavily
    set_key(rand_key(), 4'd15);
    idle_pct  = 0;
    stall_pct = 64;
    run_strings(290);
    wait_drained();

    // zero length: nothing may ever match; light idling on both sides
    set_key(rand_key(), 4'd0);
    idle_pct  = 25;
    stall_pct = 25;
    run_strings(290);
    wait_drained();

    // all-ones key; a long hold-off fills the pipe and backs up the input,
    // then the sender waits for every result before going on
    set_key('1, 4'd8);
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 300;
    run_strings(145);
    wait_drained();
    run_strings(145);
    wait_drained();

    // all-zero key of one byte, as after reset, mixed idling
    set_key('0, 4'd1);
    idle_pct  = 25;
    stall_pct = 25;
    run_strings(145);
    wait_drained();

    // random key and length, receiver stalling again
    set_key(rand_key(), 4'($urandom_range(1, 8)));
    idle_pct  = 0;
    stall_pct = 64;
    run_strings(145);
    wait_drained();

    if (mismatches == 0) begin
      $display("** query_param_extract_url_decode: PASSED **");
    end else begin
      $display("** query_param_extract_url_decode: FAILED **");
    end
    $finish;
  end

endmodule
